/* hw/rtl/ffpa_pkg.sv */
package ffpa_pkg;

    localparam int unsigned DEFAULT_PAGE_COUNT = 64;
    localparam int unsigned KERNEL_PAGES       = 4;
    localparam int unsigned PAGE_BYTES         = 1024;
    localparam int unsigned PAGE_SHIFT         = $clog2(PAGE_BYTES);
    localparam int unsigned OWNER_W            = 16;
    localparam int unsigned ADDR_W             = 32;
    localparam int unsigned PAGES_W            = 7;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_NONE    = 2'd1,
        STAT_INVALID = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_WALK,
        S_RESP
    } t_state;

endpackage

/* hw/rtl/ffpa_owner_ram.sv */
module ffpa_owner_ram #(
    parameter int unsigned DEPTH = ffpa_pkg::DEFAULT_PAGE_COUNT,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [ffpa_pkg::OWNER_W-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [AW-1:0]                i_raddr,
    output logic [ffpa_pkg::OWNER_W-1:0] o_rdata
);

    logic [ffpa_pkg::OWNER_W-1:0] r_mem [DEPTH];
    logic [ffpa_pkg::OWNER_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/first_fit_page_allocator_core.sv */
// Channel   Dir  Handshake                 Payload
// s_axis    in   tvalid/tready             tuser: action; tdata: owner_id, byte_length,
//                                          block_address
// m_axis    out  tvalid/tready             tuser: status; tdata: block_start_address,
//                                          pages_affected
// cfg       in   wr_en                     wr_data: region_base_address
//
// One request at a time; the owner table sits in a single-port-read RAM.
// Allocate: reads the table from page 0 until a fit (at most PAGE_COUNT pages), then claims the pages.
// Free: reads and clears the owner's run, one table entry per cycle; rejected requests go straight to the result.
// After reset a clearing pass writes every table entry; no word is taken then.
// A new word is taken while a finished result still waits in the output register;
// the next result holds until that register drains.
module first_fit_page_allocator_core #(
    parameter int unsigned PAGE_COUNT = ffpa_pkg::DEFAULT_PAGE_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [79:0] i_s_axis_tdata,   // owner_id[15:0], byte_length[47:16],
                                          // block_address[79:48]
    input  logic        i_s_axis_tuser,   // action[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // block_start_address[31:0], pages_affected[38:32],
                                          // zero[39]
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);

    localparam int unsigned IW     = $clog2(PAGE_COUNT);
    localparam int unsigned CW     = $clog2(PAGE_COUNT + 1);
    localparam int unsigned OW     = ffpa_pkg::OWNER_W;
    localparam int unsigned AW     = ffpa_pkg::ADDR_W;
    localparam int unsigned SH     = ffpa_pkg::PAGE_SHIFT;
    localparam int unsigned NEED_W = AW + 1 - SH;
    localparam int unsigned PG_W   = AW - SH;

    ffpa_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic              r_rd_vld, n_rd_vld;
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic [OW-1:0]     r_who, n_who;
    logic [CW-1:0]     r_need, n_need;
    logic [CW-1:0]     r_run, n_run;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [IW-1:0]     r_first, n_first;
    logic [IW-1:0]     r_wr, n_wr;
    logic [AW-1:0]     r_base;

    ffpa_pkg::t_status r_res_status, n_res_status;
    logic [AW-1:0]     r_res_addr, n_res_addr;
    logic [6:0]        r_res_pages, n_res_pages;

    logic              r_m_valid;
    ffpa_pkg::t_status r_m_status;
    logic [AW-1:0]     r_m_addr;
    logic [6:0]        r_m_pages;
    logic              load_out;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [OW-1:0]     ram_wdata;
    logic              ram_re;
    logic [OW-1:0]     ram_rdata;

    logic              in_action;
    logic [OW-1:0]     in_who;
    logic [AW-1:0]     in_len;
    logic [AW-1:0]     in_addr;
    logic [AW:0]       len_round;
    logic [NEED_W-1:0] need;
    logic [AW-1:0]     offset;
    logic [PG_W-1:0]   page;
    logic [CW-1:0]     run_n;
    logic [CW-1:0]     cnt_inc;
    logic [CW-1:0]     first_c;
    logic              finish;

    assign in_action = i_s_axis_tuser;
    assign in_who    = i_s_axis_tdata[15:0];
    assign in_len    = i_s_axis_tdata[47:16];
    assign in_addr   = i_s_axis_tdata[79:48];
    assign len_round = {1'b0, in_len} + (AW + 1)'(ffpa_pkg::PAGE_BYTES - 1);
    assign need      = len_round[AW:SH];
    assign offset    = in_addr - r_base;
    assign page      = offset[AW-1:SH];
    assign run_n     = (ram_rdata == '0) ? CW'(r_run + 1'b1) : '0;
    assign cnt_inc   = CW'(r_cnt + 1'b1);
    assign first_c   = CW'(CW'(r_rd_idx) + 1'b1 - run_n);

    ffpa_owner_ram #(
        .DEPTH (PAGE_COUNT),
        .AW    (IW)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_ptr[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_rd_vld     = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_who        = r_who;
        n_need       = r_need;
        n_run        = r_run;
        n_cnt        = r_cnt;
        n_first      = r_first;
        n_wr         = r_wr;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_res_pages  = r_res_pages;
        ram_we       = 1'b0;
        ram_waddr    = r_wr;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        load_out     = 1'b0;
        finish       = 1'b0;

        case (r_state)
            ffpa_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[IW-1:0];
                ram_wdata = (32'(r_ptr) < ffpa_pkg::KERNEL_PAGES) ? OW'(1) : '0;
                n_ptr     = CW'(r_ptr + 1'b1);
                if (r_ptr == CW'(PAGE_COUNT - 1)) begin
                    n_ptr   = '0;
                    n_state = ffpa_pkg::S_IDLE;
                end
            end
            ffpa_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_who        = in_who;
                    n_run        = '0;
                    n_cnt        = '0;
                    n_res_status = ffpa_pkg::STAT_INVALID;
                    n_res_addr   = '0;
                    n_res_pages  = '0;
                    n_state      = ffpa_pkg::S_RESP;
                    if (!in_action) begin
                        if (in_who != '0 && in_len != '0) begin
                            if (32'(need) > 32'(PAGE_COUNT)) begin
                                n_res_status = ffpa_pkg::STAT_NONE;
                            end else begin
                                n_need  = CW'(need);
                                n_ptr   = '0;
                                n_state = ffpa_pkg::S_SCAN;
                            end
                        end
                    end else begin
                        if (in_who != '0 && in_addr >= r_base
                                && 32'(page) < 32'(PAGE_COUNT)) begin
                            n_ptr   = CW'(page);
                            n_state = ffpa_pkg::S_WALK;
                        end
                    end
                end
            end
            ffpa_pkg::S_SCAN: begin
                if (r_rd_vld) begin
                    n_run = run_n;
                    if (run_n == r_need) begin
                        finish  = 1'b1;
                        n_first = first_c[IW-1:0];
                        n_wr    = first_c[IW-1:0];
                        n_cnt   = '0;
                        n_state = ffpa_pkg::S_FILL;
                    end else if (r_rd_idx == IW'(PAGE_COUNT - 1)) begin
                        finish       = 1'b1;
                        n_res_status = ffpa_pkg::STAT_NONE;
                        n_res_addr   = '0;
                        n_res_pages  = '0;
                        n_state      = ffpa_pkg::S_RESP;
                    end
                end
                if (!finish && r_ptr < CW'(PAGE_COUNT)) begin
                    ram_re   = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_ptr[IW-1:0];
                    n_ptr    = CW'(r_ptr + 1'b1);
                end
            end
            ffpa_pkg::S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_wr;
                ram_wdata = r_who;
                n_wr      = IW'(r_wr + 1'b1);
                n_cnt     = cnt_inc;
                if (cnt_inc == r_need) begin
                    n_res_status = ffpa_pkg::STAT_DONE;
                    n_res_addr   = r_base + (AW'(r_first) << SH);
                    n_res_pages  = 7'(r_need);
                    n_state      = ffpa_pkg::S_RESP;
                end
            end
            ffpa_pkg::S_WALK: begin
                if (r_rd_vld) begin
                    if (ram_rdata == r_who) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_rd_idx;
                        ram_wdata = '0;
                        n_cnt     = cnt_inc;
                        if (r_rd_idx == IW'(PAGE_COUNT - 1)) begin
                            finish       = 1'b1;
                            n_res_status = ffpa_pkg::STAT_DONE;
                            n_res_addr   = '0;
                            n_res_pages  = 7'(cnt_inc);
                            n_state      = ffpa_pkg::S_RESP;
                        end
                    end else begin
                        finish       = 1'b1;
                        n_res_status = (r_cnt == '0) ? ffpa_pkg::STAT_NONE
                                                     : ffpa_pkg::STAT_DONE;
                        n_res_addr   = '0;
                        n_res_pages  = 7'(r_cnt);
                        n_state      = ffpa_pkg::S_RESP;
                    end
                end
                if (!finish && r_ptr < CW'(PAGE_COUNT)) begin
                    ram_re   = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_ptr[IW-1:0];
                    n_ptr    = CW'(r_ptr + 1'b1);
                end
            end
            ffpa_pkg::S_RESP: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ffpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffpa_pkg::S_CLEAR;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_who        <= n_who;
        r_need       <= n_need;
        r_run        <= n_run;
        r_cnt        <= n_cnt;
        r_first      <= n_first;
        r_wr         <= n_wr;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_res_pages  <= n_res_pages;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_wr_en) begin
            r_base <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_m_status <= r_res_status;
            r_m_addr   <= r_res_addr;
            r_m_pages  <= r_res_pages;
        end
    end

    assign o_s_axis_tready = (r_state == ffpa_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {1'b0, r_m_pages, r_m_addr};
    assign o_m_axis_tuser  = r_m_status;

endmodule

/* tb/sv/ffpa_tb_pkg.sv */
package ffpa_tb_pkg;
    import ffpa_pkg::*;

    localparam bit          ACT_ALLOC  = 1'b0;
    localparam bit          ACT_FREE   = 1'b1;
    localparam int unsigned PAGE_TOTAL = DEFAULT_PAGE_COUNT;

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   start_addr;
        logic [PAGES_W-1:0]  pages;
    } reply_t;

    class page_ledger;
        logic [OWNER_W-1:0] owner_of [PAGE_TOTAL];
        logic [ADDR_W-1:0]  region_base;
        reply_t             awaited[$];
        int unsigned        mismatches;

        function new();
            for (int p = 0; p < PAGE_TOTAL; p++) begin
                owner_of[p] = (p < KERNEL_PAGES) ? 16'd1 : 16'd0;
            end
            region_base = '0;
            mismatches  = 0;
        endfunction

        function reply_t allocate(logic [OWNER_W-1:0] who, logic [31:0] len);
            reply_t      r;
            logic [32:0] need;
            int unsigned count;
            int unsigned run;
            int unsigned first;
            r = '{status: STAT_INVALID, start_addr: '0, pages: '0};
            if (who == '0 || len == '0) begin
                return r;
            end
            need = ({1'b0, len} + 33'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
            r.status = STAT_NONE;
            if (need > 33'(PAGE_TOTAL)) begin
                return r;
            end
            count = int'(need);
            run   = 0;
            first = PAGE_TOTAL;
            for (int p = 0; p < PAGE_TOTAL && first == PAGE_TOTAL; p++) begin
                run = (owner_of[p] == '0) ? run + 1 : 0;
                if (run == count) begin
                    first = p + 1 - run;
                end
            end
            if (first == PAGE_TOTAL) begin
                return r;
            end
            for (int p = first; p < first + count; p++) begin
                owner_of[p] = who;
            end
            r.status     = STAT_DONE;
            r.start_addr = region_base + 32'(first) * 32'(PAGE_BYTES);
            r.pages      = 7'(count);
            return r;
        endfunction

        function reply_t free_run(logic [OWNER_W-1:0] who, logic [31:0] addr);
            reply_t      r;
            logic [31:0] page;
            int unsigned cnt;
            r = '{status: STAT_INVALID, start_addr: '0, pages: '0};
            if (who == '0 || addr < region_base) begin
                return r;
            end
            page = (addr - region_base) >> PAGE_SHIFT;
            if (page >= PAGE_TOTAL) begin
                return r;
            end
            cnt = 0;
            for (int p = int'(page); p < PAGE_TOTAL && owner_of[p] == who; p++) begin
                owner_of[p] = '0;
                cnt++;
            end
            r.status = (cnt == 0) ? STAT_NONE : STAT_DONE;
            r.pages  = 7'(cnt);
            return r;
        endfunction

        function void note_request(bit act, logic [15:0] who, logic [31:0] len,
                                   logic [31:0] addr);
            if (act == ACT_ALLOC) begin
                awaited.push_back(allocate(who, len));
            end else begin
                awaited.push_back(free_run(who, addr));
            end
        endfunction

        function void check_reply(logic [39:0] data, logic [1:0] user);
            reply_t want;
            if (awaited.size() == 0) begin
                $error("result with no request waiting: status %0d addr 0x%08h pages %0d",
                       user, data[31:0], data[38:32]);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (user !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, user);
                mismatches++;
            end
            if (data[31:0] !== want.start_addr) begin
                $error("block_start_address: expected 0x%08h, got 0x%08h",
                       want.start_addr, data[31:0]);
                mismatches++;
            end
            if (data[38:32] !== want.pages) begin
                $error("pages_affected: expected %0d, got %0d", want.pages, data[38:32]);
                mismatches++;
            end
        endfunction
    endclass

endpackage

/* tb/sv/first_fit_page_allocator_core_tb.sv */
module first_fit_page_allocator_core_tb;
    import ffpa_pkg::*;
    import ffpa_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUIET_LIMIT    = 3000;
    localparam int unsigned RX_HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES    = 150;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic [31:0] i_cfg_wr_data   = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [79:0] i_s_axis_tdata  = '0;
    logic        i_s_axis_tuser  = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    page_ledger  ledger;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    bit          rx_hold_req  = 1'b0;

    first_fit_page_allocator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (o_m_axis_tvalid === 1'b1 && i_m_axis_tready === 1'b1) begin
            ledger.check_reply(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid === 1'b1 && o_s_axis_tready === 1'b1) ||
                (o_m_axis_tvalid === 1'b1 && i_m_axis_tready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_request(input bit act, input logic [15:0] who,
                                input logic [31:0] len, input logic [31:0] addr);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= act;
        i_s_axis_tdata  <= {addr, len, who};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        ledger.note_request(act, who, len, addr);
    endtask

    // drop valid and wait until every reply is back and the block takes words again
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (ledger.awaited.size() != 0 || o_s_axis_tready !== 1'b1);
    endtask

    task automatic write_region_base(input logic [31:0] base);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= base;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        ledger.region_base = base;
    endtask

    task automatic random_request();
        int unsigned pick;
        int unsigned pg;
        bit          act;
        logic [15:0] who;
        logic [31:0] len;
        logic [31:0] addr;
        pick = $urandom_range(99);
        who  = 16'($urandom_range(1, 12));
        len  = $urandom;
        addr = $urandom;
        if (pick < 45) begin
            act = ACT_ALLOC;
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(1, PAGE_TOTAL * PAGE_BYTES);
            end else if ($urandom_range(4) == 0) begin
                len = $urandom_range(1, 6) * PAGE_BYTES;
            end else begin
                len = $urandom_range(1, 6 * PAGE_BYTES);
            end
        end else if (pick < 88) begin
            act = ACT_FREE;
            pg  = $urandom_range(PAGE_TOTAL - 1);
            if (ledger.owner_of[pg] != '0 && $urandom_range(4) != 0) begin
                who = ledger.owner_of[pg];
            end
            // half the time back up to the head of the run
            if ($urandom_range(1) == 1) begin
                while (pg > 0 && ledger.owner_of[pg - 1] == who) begin
                    pg--;
                end
            end
            addr = ledger.region_base + 32'(pg) * 32'(PAGE_BYTES)
                 + 32'($urandom_range(PAGE_BYTES - 1));
        end else begin
            act = $urandom_range(1);
            case ($urandom_range(3))
                0:       who = '0;
                1:       who = 16'($urandom);
                2:       len = '0;
                default: ;
            endcase
        end
        send_request(act, who, len, addr);
    endtask

    task automatic run_phase(input logic [31:0] base, input int unsigned tx_pct,
                             input int unsigned rx_pct, input int unsigned items,
                             input bit squeeze);
        write_region_base(base);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (squeeze) begin
            rx_hold_req = 1'b1;
        end
        repeat (items) begin
            random_request();
        end
        settle();
    endtask

    initial begin : main
        ledger = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);

        send_request(ACT_ALLOC, 16'd0,      32'd100,              $urandom);
        send_request(ACT_ALLOC, 16'd5,      32'd0,                $urandom);
        send_request(ACT_ALLOC, 16'd5,      32'hFFFF_FFFF,        $urandom);
        send_request(ACT_ALLOC, 16'd5,      32'd65 * PAGE_BYTES,  $urandom);
        send_request(ACT_ALLOC, 16'd5,      32'd1,                $urandom);
        send_request(ACT_ALLOC, 16'hFFFF,   32'(PAGE_BYTES),      $urandom);
        send_request(ACT_ALLOC, 16'd7,      32'(PAGE_BYTES + 1),  $urandom);
        send_request(ACT_FREE,  16'd0,      $urandom,             32'd0);
        send_request(ACT_FREE,  16'd5,      $urandom,             32'd64 * PAGE_BYTES);
        send_request(ACT_FREE,  16'd5,      $urandom,             32'hFFFF_FFFF);
        send_request(ACT_FREE,  16'd9,      $urandom,             32'd4 * PAGE_BYTES);
        send_request(ACT_FREE,  16'd5,      $urandom,             32'd5 * PAGE_BYTES - 1);
        send_request(ACT_FREE,  16'hFFFF,   $urandom,             32'd5 * PAGE_BYTES);
        send_request(ACT_ALLOC, 16'd3,      32'd56 * PAGE_BYTES,  $urandom);
        send_request(ACT_FREE,  16'd3,      $urandom,             32'd8 * PAGE_BYTES);
        send_request(ACT_FREE,  16'd1,      $urandom,             32'd0);
        send_request(ACT_ALLOC, 16'd2,      32'd64 * PAGE_BYTES,  $urandom);
        send_request(ACT_FREE,  16'd7,      $urandom,             32'd6 * PAGE_BYTES + 5);
        send_request(ACT_ALLOC, 16'd2,      32'd64 * PAGE_BYTES,  $urandom);
        send_request(ACT_FREE,  16'd2,      $urandom,             32'd63 * PAGE_BYTES);
        send_request(ACT_FREE,  16'd2,      $urandom,             32'd0);
        send_request(ACT_FREE,  16'd2,      $urandom,             32'd0);
        settle();

        run_phase(32'h0001_2000,             0,  0,  80, 1'b0);
        run_phase(32'hFFFF_FFFF,             79, 0,  50, 1'b0);
        run_phase($urandom >> 1,             0,  79, 90, 1'b0);
        run_phase(32'h0000_0000,             20, 20, 90, 1'b0);
        run_phase(32'hFFFF_8000,             0,  0,  70, 1'b1);
        run_phase($urandom & 32'hFFFF_FC00,  20, 20, 70, 1'b0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
